// ----- rtl/rfsp_pkg.sv -----
// Record file stream parser package: result item layout, status and kind codes,
// parse phase encoding, header constants and the byte-wide CRC-32 step.
// No dependencies.
package rfsp_pkg;

	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
	localparam logic [31:0] LIMIT_RESET  = 32'd67108864;
	localparam logic [5:0]  HEAD_LEN     = 6'd36;
	localparam logic [5:0]  REC_HEAD_LEN = 6'd14;
	localparam logic [5:0]  MAGIC_LEN    = 6'd8;
	localparam logic [15:0] FILE_VERSION = 16'd2;
	// magic bytes, byte 0 in the low lane
	localparam logic [63:0] MAGIC        = 64'h0200_0052_4944_414E;

	localparam int unsigned OQ_DEPTH = 8;
	localparam int unsigned OQ_AW    = 3;
	localparam logic [3:0]  OQ_FULL  = 4'd8;
	localparam logic [3:0]  OQ_ROOM  = 4'd4;
	localparam logic [3:0]  OQ_PUSH_MAX = 4'd6;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_RECORD = 2'd1,
		KIND_DATA   = 2'd2,
		KIND_STATUS = 2'd3
	} rfsp_kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_MAGIC    = 3'd2,
		ST_VERSION  = 3'd3,
		ST_CRC      = 3'd4,
		ST_OVERSIZE = 3'd5,
		ST_TRUNC    = 3'd6,
		ST_TRAILING = 3'd7
	} rfsp_status_t;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_RECHEAD = 5'b00010,
		PH_PAYLOAD = 5'b00100,
		PH_AFTER   = 5'b01000,
		PH_DRAIN   = 5'b10000
	} rfsp_phase_t;

	typedef struct packed {
		rfsp_kind_t   kind;
		logic [15:0]  type_code;
		logic [63:0]  stamp;
		logic [63:0]  count;
		logic [31:0]  header_flags;
		logic [7:0]   data_byte;
		rfsp_status_t status;
		logic         last;
	} rfsp_item_t;

	typedef struct packed {
		logic [1:0] n;
		rfsp_item_t item0;
		rfsp_item_t item1;
	} rfsp_push_t;

	function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0000_0000);
		end
		return c;
	endfunction

endpackage

// ----- rtl/rfsp_if.sv -----
// Record file stream parser channels: byte input, result output, limit write.
// Depends on nothing; payload fields are plain vectors.
interface rfsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_file;
	modport source (output valid, output in_byte, output end_of_file, input ready);
	modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface rfsp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] type_code;
	logic [63:0] stamp;
	logic [63:0] count;
	logic [31:0] header_flags;
	logic [7:0]  data_byte;
	logic [2:0]  status;
	logic        last;
	modport source (output valid, output kind, output type_code, output stamp, output count,
		output header_flags, output data_byte, output status, output last, input ready);
	modport sink (input valid, input kind, input type_code, input stamp, input count,
		input header_flags, input data_byte, input status, input last, output ready);
endinterface

interface rfsp_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] payload_limit;
	modport source (output valid, output payload_limit, input ready);
	modport sink (input valid, input payload_limit, output ready);
endinterface

// ----- rtl/rfsp_core.sv -----
// Parser core: input byte register, header/record parse state, CRC-32,
// result items from the parsed bytes. Depends on rfsp_pkg.
module rfsp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        in_byte,
	input  logic              end_of_file,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_limit,
	output rfsp_pkg::rfsp_push_t push
);
	import rfsp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         eof_s1;

	logic [31:0]  limit_q;
	rfsp_phase_t  phase_q, phase_n;
	logic [5:0]   idx_q, idx_n, idx_inc;
	logic [7:0]   ver_q, ver_n;
	logic [31:0]  crc_q, crc_n;
	logic [31:0]  scrc_q, scrc_n;
	logic [63:0]  rec_q, rec_n;
	logic [31:0]  pl_q, pl_n;
	logic [15:0]  type_q, type_n;
	logic [63:0]  stamp_q, stamp_n;
	logic [31:0]  flags_q, flags_n;
	rfsp_status_t err_q, err_n;
	rfsp_status_t st;
	logic         emit;
	rfsp_item_t   emit_item, stat_item;
	logic [2:0]   hdr_lane, rec_lane;
	logic [1:0]   pl_lane;

	assign idx_inc  = idx_q + 6'd1;
	assign hdr_lane = idx_q[2:0] + 3'd4;
	assign rec_lane = idx_q[2:0] + 3'd6;
	assign pl_lane  = idx_q[1:0] + 2'd2;

	always_comb begin
		phase_n   = phase_q;
		idx_n     = idx_q;
		ver_n     = ver_q;
		scrc_n    = scrc_q;
		rec_n     = rec_q;
		pl_n      = pl_q;
		type_n    = type_q;
		stamp_n   = stamp_q;
		flags_n   = flags_q;
		err_n     = err_q;
		crc_n     = (phase_q != PH_HEADER) ? crc32_byte(crc_q, byte_s1) : crc_q;
		emit      = 1'b0;
		emit_item = '0;
		stat_item = '0;
		st        = ST_OK;
		unique case (phase_q)
			PH_HEADER: begin
				idx_n = idx_inc;
				priority if (idx_q < MAGIC_LEN) begin
					if (byte_s1 != MAGIC[{idx_q[2:0], 3'b000} +: 8] && err_q == ST_OK)
						err_n = ST_MAGIC;
				end else if (idx_q == 6'd8) begin
					ver_n = byte_s1;
				end else if (idx_q == 6'd9) begin
					if ({byte_s1, ver_q} != FILE_VERSION && err_q == ST_OK)
						err_n = ST_VERSION;
				end else if (idx_q < 6'd12) begin
					type_n[{idx_q[0], 3'b000} +: 8] = byte_s1;
				end else if (idx_q < 6'd20) begin
					stamp_n[{hdr_lane, 3'b000} +: 8] = byte_s1;
				end else if (idx_q < 6'd28) begin
					rec_n[{hdr_lane, 3'b000} +: 8] = byte_s1;
				end else if (idx_q < 6'd32) begin
					flags_n[{idx_q[1:0], 3'b000} +: 8] = byte_s1;
				end else begin
					scrc_n[{idx_q[1:0], 3'b000} +: 8] = byte_s1;
				end
				if (idx_q == HEAD_LEN - 6'd1) begin
					emit                   = 1'b1;
					emit_item.kind         = KIND_HEADER;
					emit_item.type_code    = type_q;
					emit_item.stamp        = stamp_q;
					emit_item.count        = rec_q;
					emit_item.header_flags = flags_q;
					idx_n                  = '0;
					priority if (err_q != ST_OK) phase_n = PH_DRAIN;
					else if (rec_q == '0)        phase_n = PH_AFTER;
					else                         phase_n = PH_RECHEAD;
				end
			end
			PH_RECHEAD: begin
				idx_n = idx_inc;
				priority if (idx_q == 6'd0) begin
					type_n  = {8'h00, byte_s1};
					stamp_n = '0;
					pl_n    = '0;
				end else if (idx_q == 6'd1) begin
					type_n[15:8] = byte_s1;
				end else if (idx_q < 6'd10) begin
					stamp_n[{rec_lane, 3'b000} +: 8] = byte_s1;
				end else begin
					pl_n[{pl_lane, 3'b000} +: 8] = byte_s1;
				end
				if (idx_q == REC_HEAD_LEN - 6'd1) begin
					if (pl_n > limit_q) begin
						err_n   = ST_OVERSIZE;
						phase_n = PH_DRAIN;
					end else begin
						emit                = 1'b1;
						emit_item.kind      = KIND_RECORD;
						emit_item.type_code = type_n;
						emit_item.stamp     = stamp_n;
						emit_item.count     = {32'h0000_0000, pl_n};
						if (pl_n == '0) begin
							rec_n   = rec_q - 64'd1;
							idx_n   = '0;
							phase_n = (rec_q != 64'd1) ? PH_RECHEAD : PH_AFTER;
						end else begin
							phase_n = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				emit                = 1'b1;
				emit_item.kind      = KIND_DATA;
				emit_item.data_byte = byte_s1;
				pl_n                = pl_q - 32'd1;
				if (pl_q == 32'd1) begin
					rec_n   = rec_q - 64'd1;
					idx_n   = '0;
					phase_n = (rec_q != 64'd1) ? PH_RECHEAD : PH_AFTER;
				end
			end
			PH_AFTER: begin
				err_n   = ST_TRAILING;
				phase_n = PH_DRAIN;
			end
			PH_DRAIN: begin
			end
			default: begin
			end
		endcase

		priority if (phase_n == PH_HEADER)                  st = ST_SHORT;
		else if (err_n == ST_MAGIC || err_n == ST_VERSION)  st = err_n;
		else if (~crc_n != scrc_n)                          st = ST_CRC;
		else if (err_n == ST_OVERSIZE)                      st = ST_OVERSIZE;
		else if (phase_n == PH_RECHEAD || phase_n == PH_PAYLOAD) st = ST_TRUNC;
		else if (err_n == ST_TRAILING)                      st = ST_TRAILING;
		else                                                st = ST_OK;
		stat_item.kind   = KIND_STATUS;
		stat_item.status = st;
		stat_item.last   = 1'b1;
	end

	always_comb begin
		push.n     = valid_s1 ? ({1'b0, emit} + {1'b0, eof_s1}) : 2'd0;
		push.item0 = emit ? emit_item : stat_item;
		push.item1 = stat_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_byte;
			eof_s1  <= end_of_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			ver_q   <= '0;
			crc_q   <= CRC_INIT;
			scrc_q  <= '0;
			rec_q   <= '0;
			pl_q    <= '0;
			type_q  <= '0;
			stamp_q <= '0;
			flags_q <= '0;
			err_q   <= ST_OK;
		end else if (valid_s1) begin
			if (eof_s1) begin
				phase_q <= PH_HEADER;
				idx_q   <= '0;
				ver_q   <= '0;
				crc_q   <= CRC_INIT;
				scrc_q  <= '0;
				rec_q   <= '0;
				pl_q    <= '0;
				type_q  <= '0;
				stamp_q <= '0;
				flags_q <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_n;
				idx_q   <= idx_n;
				ver_q   <= ver_n;
				crc_q   <= crc_n;
				scrc_q  <= scrc_n;
				rec_q   <= rec_n;
				pl_q    <= pl_n;
				type_q  <= type_n;
				stamp_q <= stamp_n;
				flags_q <= flags_n;
				err_q   <= err_n;
			end
		end
	end

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && eof_s1 |=> phase_q == PH_HEADER && idx_q == '0 && crc_q == CRC_INIT)
		else $error("parse state not restored after end of file");

	a_head_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> idx_q < HEAD_LEN)
		else $error("header byte index out of range");

	a_rechead_records: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RECHEAD || phase_q == PH_PAYLOAD |->
			rec_q != '0 && (phase_q == PH_PAYLOAD || idx_q < REC_HEAD_LEN))
		else $error("record parse with no records left");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.item1.kind == KIND_STATUS && push.item0.kind != KIND_STATUS)
		else $error("two results in a beat not item then status");

endmodule

// ----- rtl/rfsp_outq.sv -----
// Result queue: eight-entry buffer taking up to two items a cycle and
// handing out one per beat. Depends on rfsp_pkg.
module rfsp_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  rfsp_pkg::rfsp_push_t push,
	input  logic                pop,
	output logic                avail,
	output logic                room,
	output rfsp_pkg::rfsp_item_t head
);
	import rfsp_pkg::*;

	rfsp_item_t       mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_q, rd_q, wr_nx;
	logic [3:0]       cnt_q;
	logic             take_pop;

	assign wr_nx    = wr_q + {{(OQ_AW-1){1'b0}}, 1'b1};
	assign avail    = cnt_q != 4'd0;
	assign room     = cnt_q <= OQ_ROOM;
	assign head     = mem_q[rd_q];
	assign take_pop = pop && avail;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_q] <= push.item0;
		if (push.n == 2'd2) mem_q[wr_nx] <= push.item1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OQ_AW'(push.n);
			rd_q  <= rd_q + OQ_AW'(take_pop);
			cnt_q <= cnt_q + {2'b00, push.n} - {3'b000, take_pop};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OQ_FULL)
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> cnt_q <= OQ_PUSH_MAX)
		else $error("push without reserved room");

endmodule

// ----- rtl/record_file_stream_parser.sv -----
// Record file stream parser top level: byte channel, result channel, limit write.
// Depends on rfsp_pkg, rfsp_if, rfsp_core, rfsp_outq.
//
//  channel    dir  beat                                  notes
//  file_data  in   in_byte, end_of_file                  one file byte per beat
//  result     out  kind, type_code, stamp, count, ...    one item per beat
//  cfg        in   payload_limit                         always ready
//
// A byte is registered on acceptance and parsed in the next cycle; its items
// enter the result queue at the end of that cycle and are offered from its head.
// One byte per cycle is sustained while results drain; an end-of-file byte may
// add a second item. file_data.ready drops once more than four items wait in
// the queue. Reset clears parse state, the queue and sets payload_limit to
// 64 MiB; parse state also restarts after each file.
module record_file_stream_parser (
	input  logic            clk,
	input  logic            arst_n,
	rfsp_byte_if.sink       file_data,
	rfsp_result_if.source   result,
	rfsp_cfg_if.sink        cfg
);
	import rfsp_pkg::*;

	rfsp_push_t push;
	rfsp_item_t head;
	logic       room;
	logic       avail;

	assign file_data.ready = room;
	assign cfg.ready       = 1'b1;

	rfsp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (file_data.valid && room),
		.in_byte     (file_data.in_byte),
		.end_of_file (file_data.end_of_file),
		.cfg_we      (cfg.valid),
		.cfg_limit   (cfg.payload_limit),
		.push        (push)
	);

	rfsp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (result.ready),
		.avail  (avail),
		.room   (room),
		.head   (head)
	);

	assign result.valid        = avail;
	assign result.kind         = head.kind;
	assign result.type_code    = head.type_code;
	assign result.stamp        = head.stamp;
	assign result.count        = head.count;
	assign result.header_flags = head.header_flags;
	assign result.data_byte    = head.data_byte;
	assign result.status       = head.status;
	assign result.last         = head.last;

endmodule
